// ===== rtl/core/upa_pkg.sv =====
// ----------------------------------------------------------------------------
// upa_pkg - shared definitions for the units per allocation selector
// Widths, limits and the divider result bundle used by the core and its
// shared divider.
// ----------------------------------------------------------------------------
package upa_pkg;

  localparam int MAX_GROUPS  = 16;
  localparam int MAX_UNITS   = 64;

  localparam int CPUS_W      = 10;
  localparam int UNITS_W     = 7;
  localparam int ALLOC_W     = 14;
  localparam int TOTAL_W     = 14;
  localparam int GIDX_W      = $clog2(MAX_GROUPS);
  localparam int GCNT_W      = GIDX_W + 1;

  // Dividend is count + units - 1, one bit wider than a group count.
  localparam int DIVIDEND_W  = CPUS_W + 1;
  localparam int DSTEP_W     = $clog2(DIVIDEND_W + 1);
  // Waste per group stays below MAX_UNITS, summed over all groups.
  localparam int WASTE_W     = UNITS_W + GIDX_W;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [UNITS_W-1:0]    remainder;
  } div_res_t;

endpackage

// ===== rtl/core/upa_div.sv =====
// ----------------------------------------------------------------------------
// upa_div - shared restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient and remainder are ready.
// ----------------------------------------------------------------------------
module upa_div
  import upa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [UNITS_W-1:0]    divisor,
  output div_res_t              res
);

  logic                  running_r, running_nxt;
  logic                  done_r, done_nxt;
  logic [DSTEP_W-1:0]    step_r, step_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [UNITS_W-1:0]    rem_r, rem_nxt;
  logic [UNITS_W-1:0]    dsr_r, dsr_nxt;
  logic [UNITS_W:0]      trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    running_nxt = running_r;
    done_nxt    = 1'b0;
    step_nxt    = step_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dsr_nxt     = dsr_r;
    if (go) begin
      running_nxt = 1'b1;
      step_nxt    = DSTEP_W'(DIVIDEND_W);
      quo_nxt     = dividend;
      rem_nxt     = '0;
      dsr_nxt     = divisor;
    end else if (running_r) begin
      // The remainder always ends below the divisor, so it fits UNITS_W bits.
      if (fits) begin
        rem_nxt = UNITS_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[UNITS_W-1:0];
      end
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
      step_nxt = step_r - DSTEP_W'(1);
      if (step_r == DSTEP_W'(1)) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      running_r <= running_nxt;
      done_r    <= done_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

// ===== rtl/core/units_per_allocation_select_unit.sv =====
// ----------------------------------------------------------------------------
// units_per_allocation_select_unit - units per allocation search
// Stores group processor counts and picks the unit count that keeps waste
// within a third of the total while allocations stop growing.
// ----------------------------------------------------------------------------
// A group that is not the last is stored and busy stays low. The last
// group starts the search: for each unit count u tried, every stored group
// goes through the shared 11-step divider and then u is evaluated; u counts
// down from the saturated starting unit count and stops at 1 at the latest.
// The result appears on out_best_units and out_allocation_count for exactly
// one cycle with out_valid high and must be taken then; the receiver cannot
// stall it. A group that arrives while 16 are stored is dropped.
module units_per_allocation_select_unit
  import upa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [CPUS_W-1:0]  in_group_cpus,
  input  logic [UNITS_W-1:0] in_start_units,
  input  logic               in_last_group,
  output logic               out_valid,
  output logic [UNITS_W-1:0] out_best_units,
  output logic [ALLOC_W-1:0] out_allocation_count
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [GCNT_W-1:0]  count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [GCNT_W-1:0]  gidx_r, gidx_nxt;
  logic [UNITS_W-1:0] units_r, units_nxt;
  logic [ALLOC_W-1:0] allocs_r, allocs_nxt;
  logic [WASTE_W-1:0] waste_r, waste_nxt;
  logic [ALLOC_W-1:0] prev_r, prev_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [UNITS_W-1:0] chosen_r, chosen_nxt;
  logic [ALLOC_W-1:0] chosen_allocs_r, chosen_allocs_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [UNITS_W-1:0] out_units_r;
  logic [ALLOC_W-1:0] out_allocs_r;

  logic [CPUS_W-1:0]  group_store_r [MAX_GROUPS];
  logic               accept;
  logic               store_we;
  logic [CPUS_W-1:0]  cur_cpus;
  logic               div_go;
  logic [DIVIDEND_W-1:0] div_dividend;
  div_res_t           div_res;
  logic [UNITS_W-1:0] start_sat;
  logic [TOTAL_W-1:0] waste_x3;
  logic               over_waste;

  assign accept   = start && !busy;
  assign store_we = accept && (count_r < GCNT_W'(MAX_GROUPS));
  assign cur_cpus = group_store_r[gidx_r[GIDX_W-1:0]];

  always_comb begin
    if (in_start_units == '0) begin
      start_sat = UNITS_W'(1);
    end else if (in_start_units > UNITS_W'(MAX_UNITS)) begin
      start_sat = UNITS_W'(MAX_UNITS);
    end else begin
      start_sat = in_start_units;
    end
  end

  // Ceiling division is the floor of (count + u - 1) / u.
  assign div_dividend = {1'b0, cur_cpus} + DIVIDEND_W'(units_r) - DIVIDEND_W'(1);

  // waste > total / 3 holds exactly when 3 * waste > total.
  assign waste_x3   = TOTAL_W'({waste_r, 1'b0}) + TOTAL_W'(waste_r);
  assign over_waste = (waste_x3 > total_r);

  upa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (units_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    total_nxt         = total_r;
    gidx_nxt          = gidx_r;
    units_nxt         = units_r;
    allocs_nxt        = allocs_r;
    waste_nxt         = waste_r;
    prev_nxt          = prev_r;
    have_prev_nxt     = have_prev_r;
    chosen_nxt        = chosen_r;
    chosen_allocs_nxt = chosen_allocs_r;
    out_valid_nxt     = 1'b0;
    div_go            = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (store_we) begin
            count_nxt = count_r + GCNT_W'(1);
            total_nxt = total_r + TOTAL_W'(in_group_cpus);
          end
          if (in_last_group) begin
            state_nxt         = ST_LOAD;
            units_nxt         = start_sat;
            gidx_nxt          = '0;
            allocs_nxt        = '0;
            waste_nxt         = '0;
            have_prev_nxt     = 1'b0;
            chosen_nxt        = UNITS_W'(1);
            chosen_allocs_nxt = '0;
          end
        end
      end
      ST_LOAD: begin
        if (gidx_r == count_r) begin
          state_nxt = ST_EVAL;
        end else begin
          div_go    = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          allocs_nxt = allocs_r + ALLOC_W'(div_res.quotient);
          waste_nxt  = waste_r + WASTE_W'(units_r - UNITS_W'(1) - div_res.remainder);
          gidx_nxt   = gidx_r + GCNT_W'(1);
          state_nxt  = ST_LOAD;
        end
      end
      ST_EVAL: begin
        if (!over_waste && have_prev_r && (allocs_r > prev_r)) begin
          state_nxt = ST_DONE;
        end else begin
          if (!over_waste) begin
            prev_nxt          = allocs_r;
            have_prev_nxt     = 1'b1;
            chosen_nxt        = units_r;
            chosen_allocs_nxt = allocs_r;
          end
          if (units_r == UNITS_W'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            units_nxt  = units_r - UNITS_W'(1);
            gidx_nxt   = '0;
            allocs_nxt = '0;
            waste_nxt  = '0;
            state_nxt  = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        count_nxt     = '0;
        total_nxt     = '0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gidx_r          <= gidx_nxt;
    units_r         <= units_nxt;
    allocs_r        <= allocs_nxt;
    waste_r         <= waste_nxt;
    prev_r          <= prev_nxt;
    have_prev_r     <= have_prev_nxt;
    chosen_r        <= chosen_nxt;
    chosen_allocs_r <= chosen_allocs_nxt;
    if (state_r == ST_DONE) begin
      out_units_r  <= chosen_r;
      out_allocs_r <= chosen_allocs_r;
    end
    if (store_we) begin
      group_store_r[count_r[GIDX_W-1:0]] <= in_group_cpus;
    end
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_best_units       = out_units_r;
  assign out_allocation_count = out_allocs_r;

endmodule
